[rtl/htn_pkg.sv]
// ----------------------------------------------------------------------------
// htn_pkg: shared types and constants of the height to normal map block
// Sizes, register indexes, state and command codes used by all but htn_ram.
// ----------------------------------------------------------------------------
package htn_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W + 1;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH;
  localparam int DIM_W       = 11;
  localparam int GAIN_W      = 8;
  localparam int SAMPLE_W    = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd2;

  localparam logic [DIM_W-1:0]  RESET_WIDTH = 11'd256;
  localparam logic [DIM_W-1:0]  RESET_ROWS  = 11'd256;
  localparam logic [GAIN_W-1:0] RESET_GAIN  = 8'd16;

  localparam logic [16:0] PACK_SCALE = 17'd65025;
  localparam logic [15:0] Z_TERM     = 16'd16;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic [1:0] SLOT_PC = 2'd0;
  localparam logic [1:0] SLOT_PL = 2'd1;
  localparam logic [1:0] SLOT_PR = 2'd2;
  localparam logic [1:0] SLOT_QC = 2'd3;
  localparam logic [2:0] READ_LAST = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_READ, OP_XM, OP_YM, OP_XX, OP_YY,
    OP_NN, OP_RHS, OP_AA, OP_LHS, OP_CMP, OP_UPD
  } op_t;

  typedef enum logic [1:0] {
    EM_NONE, EM_UPPER, EM_PREV, EM_FINAL
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_XM, ST_YM, ST_XX, ST_YY, ST_NN,
    ST_RHS, ST_AA, ST_LHS, ST_CMP, ST_OUT, ST_UPD
  } state_t;

  typedef struct packed {
    op_t        op;
    emit_t      emit;
    logic [1:0] comp;
    logic [2:0] bitx;
    logic [2:0] rd_step;
  } cmd_t;

  typedef struct packed {
    logic en_upper;
    logic en_prev;
    logic en_final;
  } status_t;

endpackage

[rtl/height_to_normal_map.sv]
// ----------------------------------------------------------------------------
// height_to_normal_map: packed unit normals from a raster height stream
// A sample passes the line store reads and, for each result it causes (up
// to three), the shared multiplier: 4 steps to form the normal and 26
// steps per component for its 8-step exact packing search.
// One sample is in work at a time; output lags the input by one row.
// Synchronous reset clears counters, recent samples and configuration; the
// line store holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module height_to_normal_map (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [htn_pkg::SAMPLE_W-1:0]   height_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     normal_red,
  output logic [7:0]                     normal_green,
  output logic [7:0]                     normal_blue,
  output logic                           last_of_run,
  output logic                           end_of_image,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htn_pkg::CFG_DATA_W-1:0] cfg_data
);

  htn_pkg::cmd_t    cmd;
  htn_pkg::status_t status;

  assign cfg_ready = 1'b1;

  htn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .last_of_run (last_of_run),
    .end_of_image(end_of_image),
    .status      (status),
    .cmd         (cmd)
  );

  htn_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .height_sample(height_sample),
    .cmd          (cmd),
    .status       (status),
    .normal_red   (normal_red),
    .normal_green (normal_green),
    .normal_blue  (normal_blue)
  );

endmodule

[rtl/htn_ram.sv]
// ----------------------------------------------------------------------------
// htn_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/htn_ctrl.sv]
// ----------------------------------------------------------------------------
// htn_ctrl: sequencer of the height to normal map block
// Steps each sample through line store reads, the shared multiplier
// sequence of every result, the output handshake and the state update.
// ----------------------------------------------------------------------------
module htn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             last_of_run,
  output logic             end_of_image,
  input  htn_pkg::status_t status,
  output htn_pkg::cmd_t    cmd
);

  htn_pkg::state_t state, state_next;
  htn_pkg::emit_t  emit, emit_next;
  logic [1:0]      comp, comp_next;
  logic [2:0]      bitx, bitx_next;
  logic [2:0]      rd_step, rd_step_next;
  htn_pkg::emit_t  first_emit, after_emit;

  function automatic htn_pkg::emit_t next_emit(htn_pkg::emit_t cur, htn_pkg::status_t st);
    htn_pkg::emit_t nx;
    nx = htn_pkg::EM_NONE;
    unique case (cur)
      htn_pkg::EM_NONE: begin
        if (st.en_upper) nx = htn_pkg::EM_UPPER;
        else if (st.en_prev) nx = htn_pkg::EM_PREV;
        else if (st.en_final) nx = htn_pkg::EM_FINAL;
      end
      htn_pkg::EM_UPPER: begin
        if (st.en_prev) nx = htn_pkg::EM_PREV;
        else if (st.en_final) nx = htn_pkg::EM_FINAL;
      end
      htn_pkg::EM_PREV: begin
        if (st.en_final) nx = htn_pkg::EM_FINAL;
      end
      htn_pkg::EM_FINAL: nx = htn_pkg::EM_NONE;
      default: nx = htn_pkg::EM_NONE;
    endcase
    return nx;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= htn_pkg::ST_IDLE;
      emit    <= htn_pkg::EM_NONE;
      comp    <= htn_pkg::COMP_X;
      bitx    <= 3'd0;
      rd_step <= 3'd0;
    end else begin
      state   <= state_next;
      emit    <= emit_next;
      comp    <= comp_next;
      bitx    <= bitx_next;
      rd_step <= rd_step_next;
    end
  end

  assign first_emit   = next_emit(htn_pkg::EM_NONE, status);
  assign after_emit   = next_emit(emit, status);
  assign last_of_run  = (after_emit == htn_pkg::EM_NONE);
  assign end_of_image = (emit == htn_pkg::EM_FINAL);

  always_comb begin
    state_next   = state;
    emit_next    = emit;
    comp_next    = comp;
    bitx_next    = bitx;
    rd_step_next = rd_step;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.op       = htn_pkg::OP_NONE;
    cmd.emit     = emit;
    cmd.comp     = comp;
    cmd.bitx     = bitx;
    cmd.rd_step  = rd_step;
    unique case (state)
      htn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op       = htn_pkg::OP_LOAD;
          rd_step_next = 3'd0;
          state_next   = htn_pkg::ST_READ;
        end
      end
      htn_pkg::ST_READ: begin
        cmd.op = htn_pkg::OP_READ;
        if (rd_step == htn_pkg::READ_LAST) begin
          emit_next  = first_emit;
          state_next = (first_emit == htn_pkg::EM_NONE) ? htn_pkg::ST_UPD : htn_pkg::ST_XM;
        end else begin
          rd_step_next = rd_step + 3'd1;
        end
      end
      htn_pkg::ST_XM: begin
        cmd.op     = htn_pkg::OP_XM;
        state_next = htn_pkg::ST_YM;
      end
      htn_pkg::ST_YM: begin
        cmd.op     = htn_pkg::OP_YM;
        state_next = htn_pkg::ST_XX;
      end
      htn_pkg::ST_XX: begin
        cmd.op     = htn_pkg::OP_XX;
        state_next = htn_pkg::ST_YY;
      end
      htn_pkg::ST_YY: begin
        cmd.op     = htn_pkg::OP_YY;
        comp_next  = htn_pkg::COMP_X;
        state_next = htn_pkg::ST_NN;
      end
      htn_pkg::ST_NN: begin
        cmd.op     = htn_pkg::OP_NN;
        bitx_next  = 3'd7;
        state_next = htn_pkg::ST_RHS;
      end
      htn_pkg::ST_RHS: begin
        cmd.op     = htn_pkg::OP_RHS;
        state_next = htn_pkg::ST_AA;
      end
      htn_pkg::ST_AA: begin
        cmd.op     = htn_pkg::OP_AA;
        state_next = htn_pkg::ST_LHS;
      end
      htn_pkg::ST_LHS: begin
        cmd.op     = htn_pkg::OP_LHS;
        state_next = htn_pkg::ST_CMP;
      end
      htn_pkg::ST_CMP: begin
        cmd.op = htn_pkg::OP_CMP;
        if (bitx == 3'd0) begin
          if (comp == htn_pkg::COMP_Z) begin
            state_next = htn_pkg::ST_OUT;
          end else begin
            comp_next  = comp + 2'd1;
            state_next = htn_pkg::ST_NN;
          end
        end else begin
          bitx_next  = bitx - 3'd1;
          state_next = htn_pkg::ST_AA;
        end
      end
      htn_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          emit_next  = after_emit;
          state_next = (after_emit == htn_pkg::EM_NONE) ? htn_pkg::ST_UPD : htn_pkg::ST_XM;
        end
      end
      htn_pkg::ST_UPD: begin
        cmd.op     = htn_pkg::OP_UPD;
        state_next = htn_pkg::ST_IDLE;
      end
      default: state_next = htn_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/htn_datapath.sv]
// ----------------------------------------------------------------------------
// htn_datapath: datapath of the height to normal map block
// Holds the configuration, counters, line store and neighbor samples, and
// runs the shared multiplier that forms and packs each unit normal.
// ----------------------------------------------------------------------------
module htn_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [htn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [htn_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [htn_pkg::SAMPLE_W-1:0]         height_sample,
  input  htn_pkg::cmd_t                        cmd,
  output htn_pkg::status_t                     status,
  output logic [7:0]                           normal_red,
  output logic [7:0]                           normal_green,
  output logic [7:0]                           normal_blue
);

  logic [htn_pkg::DIM_W-1:0]    cfg_width, cfg_rows;
  logic [htn_pkg::GAIN_W-1:0]   cfg_gain;
  logic [htn_pkg::COL_W-1:0]    column_count;
  logic [htn_pkg::ROW_W-1:0]    row_count;
  logic [htn_pkg::SAMPLE_W-1:0] rs0, rs1, h, pc, pl, pr, qc;
  logic [15:0]                  xm, ym, aa;
  logic                         xneg, yneg;
  logic [32:0]                  s;
  logic [31:0]                  nn;
  logic [47:0]                  rhs;
  logic [48:0]                  lhs;
  logic [7:0]                   k_x, k_y, k_z;

  logic [htn_pkg::DIM_W-1:0]    w_eff, rows_eff, w_m1, rows_m1, c_ext, c_inc;
  logic [htn_pkg::COL_W-1:0]    lc, rc;
  logic                         last_col, last_row;
  logic [htn_pkg::ADDR_W-1:0]   raddr, waddr;
  logic [htn_pkg::SAMPLE_W-1:0] rdata;
  logic [7:0]                   up, down, left, right;
  logic [8:0]                   dv, dh;
  logic [7:0]                   dv_mag, dh_mag;
  logic [15:0]                  nm;
  logic                         nneg, nzero;
  logic [7:0]                   kcur, t, amag;
  logic                         fit;
  logic [16:0]                  mul_a;
  logic [33:0]                  mul_b;
  logic [50:0]                  prod;
  logic [2:0]                   cap;

  assign w_eff = (cfg_width == '0) ? htn_pkg::DIM_W'(1) :
                 (cfg_width > htn_pkg::DIM_W'(htn_pkg::MAX_WIDTH)) ?
                 htn_pkg::DIM_W'(htn_pkg::MAX_WIDTH) : cfg_width;
  assign rows_eff = (cfg_rows == '0) ? htn_pkg::DIM_W'(1) :
                    (cfg_rows > htn_pkg::DIM_W'(htn_pkg::MAX_ROWS)) ?
                    htn_pkg::DIM_W'(htn_pkg::MAX_ROWS) : cfg_rows;
  assign w_m1     = w_eff - htn_pkg::DIM_W'(1);
  assign rows_m1  = rows_eff - htn_pkg::DIM_W'(1);
  assign c_ext    = htn_pkg::DIM_W'(column_count);
  assign c_inc    = c_ext + htn_pkg::DIM_W'(1);
  assign last_col = (c_ext >= w_m1);
  assign last_row = (htn_pkg::DIM_W'(row_count) >= rows_m1);
  assign lc = (column_count != '0) ? column_count - htn_pkg::COL_W'(1) : '0;
  assign rc = (c_inc <= w_m1) ? c_inc[htn_pkg::COL_W-1:0] : w_m1[htn_pkg::COL_W-1:0];

  assign status.en_upper = (row_count != '0);
  assign status.en_prev  = last_row && (column_count != '0);
  assign status.en_final = last_row && last_col;

  always_comb begin
    unique case (cmd.rd_step[1:0])
      htn_pkg::SLOT_PC: raddr = {~row_count[0], column_count};
      htn_pkg::SLOT_PL: raddr = {~row_count[0], lc};
      htn_pkg::SLOT_PR: raddr = {~row_count[0], rc};
      htn_pkg::SLOT_QC: raddr = {row_count[0], column_count};
      default:          raddr = '0;
    endcase
  end

  assign waddr = {row_count[0], column_count};
  assign cap   = cmd.rd_step - 3'd1;

  htn_ram #(
    .WIDTH(htn_pkg::SAMPLE_W),
    .DEPTH(htn_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (cmd.op == htn_pkg::OP_UPD),
    .waddr(waddr),
    .wdata(h),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    unique case (cmd.emit)
      htn_pkg::EM_UPPER: begin
        up    = (row_count >= htn_pkg::ROW_W'(2)) ? qc : pc;
        down  = h;
        left  = pl;
        right = pr;
      end
      htn_pkg::EM_PREV: begin
        up    = (row_count != '0) ? pl : rs0;
        down  = rs0;
        left  = (column_count >= htn_pkg::COL_W'(2)) ? rs1 : rs0;
        right = h;
      end
      htn_pkg::EM_FINAL: begin
        up    = (row_count != '0) ? pc : h;
        down  = h;
        left  = (column_count != '0) ? rs0 : h;
        right = h;
      end
      default: begin
        up    = '0;
        down  = '0;
        left  = '0;
        right = '0;
      end
    endcase
  end

  assign dv     = {1'b0, down} - {1'b0, up};
  assign dh     = {1'b0, right} - {1'b0, left};
  assign dv_mag = dv[8] ? 8'(-dv) : dv[7:0];
  assign dh_mag = dh[8] ? 8'(-dh) : dh[7:0];

  always_comb begin
    unique case (cmd.comp)
      htn_pkg::COMP_X: begin
        nm   = xm;
        nneg = xneg;
        kcur = k_x;
      end
      htn_pkg::COMP_Y: begin
        nm   = ym;
        nneg = yneg;
        kcur = k_y;
      end
      default: begin
        nm   = htn_pkg::Z_TERM;
        nneg = 1'b0;
        kcur = k_z;
      end
    endcase
  end

  assign nzero = (nm == '0);
  assign t     = kcur | 8'(8'd1 << cmd.bitx);
  assign amag  = t[7] ? {t[6:0], 1'b1} : ~{t[6:0], 1'b0};
  assign fit   = !t[7] ? (!nneg || nzero || (lhs >= {1'b0, rhs}))
                       : (!nneg && !nzero && (lhs <= {1'b0, rhs}));

  always_comb begin
    unique case (cmd.op)
      htn_pkg::OP_XM: begin
        mul_a = 17'(cfg_gain);
        mul_b = 34'(dv_mag);
      end
      htn_pkg::OP_YM: begin
        mul_a = 17'(cfg_gain);
        mul_b = 34'(dh_mag);
      end
      htn_pkg::OP_XX: begin
        mul_a = 17'(xm);
        mul_b = 34'(xm);
      end
      htn_pkg::OP_YY: begin
        mul_a = 17'(ym);
        mul_b = 34'(ym);
      end
      htn_pkg::OP_NN: begin
        mul_a = 17'(nm);
        mul_b = 34'(nm);
      end
      htn_pkg::OP_RHS: begin
        mul_a = htn_pkg::PACK_SCALE;
        mul_b = 34'(nn);
      end
      htn_pkg::OP_AA: begin
        mul_a = 17'(amag);
        mul_b = 34'(amag);
      end
      htn_pkg::OP_LHS: begin
        mul_a = 17'(aa);
        mul_b = 34'(s);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 51'(mul_a) * 51'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width    <= htn_pkg::RESET_WIDTH;
      cfg_rows     <= htn_pkg::RESET_ROWS;
      cfg_gain     <= htn_pkg::RESET_GAIN;
      column_count <= '0;
      row_count    <= '0;
      rs0          <= '0;
      rs1          <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          htn_pkg::REG_WIDTH: cfg_width <= cfg_data;
          htn_pkg::REG_ROWS:  cfg_rows  <= cfg_data;
          htn_pkg::REG_GAIN:  cfg_gain  <= cfg_data[htn_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == htn_pkg::OP_UPD) begin
        rs1 <= rs0;
        rs0 <= h;
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + htn_pkg::ROW_W'(1);
        end else begin
          column_count <= column_count + htn_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      htn_pkg::OP_LOAD: h <= height_sample;
      htn_pkg::OP_READ: begin
        if (cmd.rd_step != 3'd0) begin
          unique case (cap[1:0])
            htn_pkg::SLOT_PC: pc <= rdata;
            htn_pkg::SLOT_PL: pl <= rdata;
            htn_pkg::SLOT_PR: pr <= rdata;
            htn_pkg::SLOT_QC: qc <= rdata;
            default: ;
          endcase
        end
      end
      htn_pkg::OP_XM: begin
        xm   <= prod[15:0];
        xneg <= !dv[8] && (dv != '0);
      end
      htn_pkg::OP_YM: begin
        ym   <= prod[15:0];
        yneg <= !dh[8] && (dh != '0);
      end
      htn_pkg::OP_XX: s <= {1'b0, prod[31:0]};
      htn_pkg::OP_YY: s <= s + {1'b0, prod[31:0]} + 33'd256;
      htn_pkg::OP_NN: begin
        nn <= prod[31:0];
        unique case (cmd.comp)
          htn_pkg::COMP_X: k_x <= '0;
          htn_pkg::COMP_Y: k_y <= '0;
          default:         k_z <= '0;
        endcase
      end
      htn_pkg::OP_RHS: rhs <= prod[47:0];
      htn_pkg::OP_AA:  aa  <= prod[15:0];
      htn_pkg::OP_LHS: lhs <= prod[48:0];
      htn_pkg::OP_CMP: begin
        if (fit) begin
          unique case (cmd.comp)
            htn_pkg::COMP_X: k_x <= t;
            htn_pkg::COMP_Y: k_y <= t;
            default:         k_z <= t;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign normal_red   = k_x;
  assign normal_green = k_y;
  assign normal_blue  = k_z;

endmodule
